// ===== hw/rtl/sha_pkg.sv =====
package sha_pkg;

    typedef struct packed {
        logic       load_byte;   // write a message byte at the fill position
        logic       pad_first;   // write 0x80 at the fill position, zero the rest
        logic       pad_zero;    // zero the whole buffer
        logic       put_length;  // write bit length into bytes 56..63
        logic       start;       // begin a compression
        logic       finish;      // reset chaining value and counter
    } t_dp_cmd;

    typedef struct packed {
        logic       busy;        // compression running or its result being folded
        logic [5:0] fill;        // buffer fill
    } t_dp_status;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== hw/rtl/sha_datapath.sv =====
module sha_datapath
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic [2:0]  i_rd_index,
    output t_dp_status  o_status,
    output logic [31:0] o_rd_word
);

    // The block buffer is kept as sixteen big-endian words, byte 0 in bits 31:24 of word 0.
    logic [31:0] r_buf [16];
    logic [31:0] r_w   [16];
    logic [31:0] r_v   [8];
    logic [31:0] r_h   [8];
    logic [60:0] r_cnt;
    logic [6:0]  r_round;
    logic        r_busy;
    logic        r_done;

    logic [63:0] bits;
    logic [31:0] w_new, t1, t2, x15, x2, s0, s1, big0, big1, choose, major;
    logic [3:0]  ri;
    logic [5:0]  fill;

    assign fill = r_cnt[5:0];
    assign bits = {r_cnt, 3'b000};
    assign ri   = r_round[3:0];

    always_comb begin
        x15 = r_w[ri + 4'd1];
        x2  = r_w[ri + 4'd14];
        s0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
        s1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
        if (r_round < 7'd16) begin
            w_new = r_buf[ri];
        end else begin
            w_new = r_w[ri] + s0 + r_w[ri + 4'd9] + s1;
        end
        big1   = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        choose = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1     = r_v[7] + big1 + choose + ROUND_K[r_round[5:0]] + w_new;
        big0   = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        major  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2     = big0 + major;
    end

    // Byte buffer, schedule window and working variables hold payload only.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 16; k++) begin
            for (int j = 0; j < 4; j++) begin
                if (i_cmd.pad_zero) begin
                    r_buf[k][31 - 8 * j -: 8] <= '0;
                end else if (i_cmd.pad_first && (4 * k + j) > int'(fill)) begin
                    r_buf[k][31 - 8 * j -: 8] <= '0;
                end else if (i_cmd.pad_first && (4 * k + j) == int'(fill)) begin
                    r_buf[k][31 - 8 * j -: 8] <= PAD_BYTE;
                end else if (i_cmd.load_byte && (4 * k + j) == int'(fill)) begin
                    r_buf[k][31 - 8 * j -: 8] <= i_data_byte;
                end else if (i_cmd.put_length && k >= 14) begin
                    r_buf[k][31 - 8 * j -: 8] <= bits[63 - 8 * (4 * (k - 14) + j) -: 8];
                end
            end
        end
        if (i_cmd.start) begin
            for (int k = 0; k < 8; k++) r_v[k] <= r_h[k];
        end else if (r_busy) begin
            r_w[ri] <= w_new;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) r_h[k] <= H_INIT[k];
            r_cnt   <= '0;
            r_round <= '0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.finish) begin
                r_cnt <= '0;
            end else if (i_cmd.load_byte) begin
                r_cnt <= r_cnt + 61'd1;
            end
            if (i_cmd.start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                r_round <= r_round + 7'd1;
                if (r_round == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                for (int k = 0; k < 8; k++) r_h[k] <= H_INIT[k];
            end else if (r_done) begin
                for (int k = 0; k < 8; k++) r_h[k] <= r_h[k] + r_v[k];
            end
        end
    end

    assign o_status.busy = r_busy | r_done;
    assign o_status.fill = fill;
    assign o_rd_word     = r_h[i_rd_index];

endmodule

// ===== hw/rtl/sha_control.sv =====
module sha_control
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    input  t_dp_status  i_status,
    output t_dp_cmd     o_cmd,
    output logic [2:0]  o_rd_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_last_word
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_BLOCK = 7'b0000010,
        S_PAD   = 7'b0000100,
        S_PAD1  = 7'b0001000,
        S_PAD2  = 7'b0010000,
        S_FINAL = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_idx, n_idx;
    logic       r_end, n_end;
    // The compression has completed and the chaining value is updated.
    logic       settled;

    assign settled = !i_status.busy;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_end   = r_end;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_byte = i_byte_present;
                    n_end = i_end_of_message;
                    if (i_byte_present && i_status.fill == 6'd63) begin
                        o_cmd.start = 1'b0;
                        n_state = S_BLOCK;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_BLOCK: begin
                // Buffer is now full; compress it.
                o_cmd.start = 1'b1;
                n_state = S_FINAL;
            end
            S_FINAL: begin
                if (settled) begin
                    if (!r_end) begin
                        n_state = S_IDLE;
                    end else if (i_status.fill == 6'd0) begin
                        // The closing byte filled a block; padding starts a fresh one.
                        n_state = S_PAD;
                    end else begin
                        // The length spilled into a second block; zero it, then length.
                        n_state = S_PAD2;
                    end
                end
            end
            S_PAD: begin
                o_cmd.pad_first = 1'b1;
                n_end = 1'b0;
                if (i_status.fill >= LEN_START) begin
                    o_cmd.start = 1'b0;
                    n_state = S_PAD1;
                end else begin
                    n_state = S_PAD2;
                end
            end
            S_PAD1: begin
                o_cmd.start = 1'b1;
                n_state = S_FINAL;
                n_end = 1'b1;
            end
            S_PAD2: begin
                if (settled) begin
                    if (r_end) begin
                        o_cmd.pad_zero = 1'b1;
                        n_end = 1'b0;
                    end else begin
                        o_cmd.put_length = 1'b1;
                        o_cmd.start = 1'b1;
                        n_idx = '0;
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                o_valid = settled;
                if (settled && i_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        o_cmd.finish = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_end   <= n_end;
        end
    end

    assign o_rd_index  = r_idx;
    assign o_last_word = (r_idx == 3'd7);

endmodule

// ===== hw/rtl/sha256_stream_hasher.sv =====
// SHA-256 over a byte stream. An item with i_byte_present adds one byte; an item
// with i_end_of_message closes the message, pads it and returns eight digest words,
// word 0 first, the last flagged. Byte items that do not fill a block leave the
// input ready for the next item. After an item that completes a 64-byte block the
// next item waits until the single round unit has been started, has run the 64
// compression rounds one per cycle and has folded the result into the chaining
// value. The first digest word is offered once the closing compression has settled;
// a second compression is needed when the closing byte fills a block, or the length
// does not fit behind the pad byte. Input is held off until the last digest word is taken.
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic [2:0] rd_index;

    sha_control u_control (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .i_status         (status),
        .o_cmd            (cmd),
        .o_rd_index       (rd_index),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_last_word      (o_last_word)
    );

    sha_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_data_byte (i_data_byte),
        .i_rd_index  (rd_index),
        .o_status    (status),
        .o_rd_word   (o_digest_word)
    );

    assign o_word_index = rd_index;

endmodule

// ===== tb/sha256_checker.sv =====
`timescale 1ns / 1ps

module sha256_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [31:0] o_digest_word,
    input  logic [2:0]  o_word_index,
    input  logic        o_last_word,
    output int          o_fail_count,
    output int          o_words_pending,
    output int          o_words_checked
);

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_word;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] KTAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic [31:0]  hash_state [8];
    logic [7:0]   msg_block [64];
    logic [60:0]  msg_bytes;
    t_digest_word digest_q [$];
    int           fails;
    int           checked;

    assign o_fail_count    = fails;
    assign o_words_pending = digest_q.size();
    assign o_words_checked = checked;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic run_rounds();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
            end else begin
                w[r] = w[r-16] + w[r-7]
                     + (ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3))
                     + (ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10));
            end
        end
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[r] + w[r];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
    endtask

    task automatic absorb_item(input logic [7:0] data, input logic present, input logic eom);
        logic [63:0]  bit_len;
        int           pos;
        t_digest_word dw;
        if (present) begin
            msg_block[msg_bytes[5:0]] = data;
            msg_bytes = msg_bytes + 61'd1;
            if (msg_bytes[5:0] == 6'd0) run_rounds();
        end
        if (eom) begin
            bit_len = {msg_bytes, 3'b000};
            pos = int'(msg_bytes[5:0]);
            msg_block[pos] = 8'h80;
            pos++;
            // The length field does not fit behind the pad byte, so one more block is needed.
            if (pos > 56) begin
                while (pos < 64) msg_block[pos++] = 8'h00;
                run_rounds();
                pos = 0;
            end
            while (pos < 56) msg_block[pos++] = 8'h00;
            for (int i = 0; i < 8; i++) msg_block[56+i] = bit_len[63-8*i -: 8];
            run_rounds();
            for (int i = 0; i < 8; i++) begin
                dw.word = hash_state[i];
                dw.idx  = 3'(i);
                dw.last = (i == 7);
                digest_q = {digest_q, dw};
            end
            for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
            msg_bytes = '0;
        end
    endtask

    initial begin
        fails   = 0;
        checked = 0;
    end

    always @(posedge i_clk) begin
        t_digest_word exp_w;
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
            msg_bytes = '0;
            digest_q.delete();
        end else begin
            if (i_valid && o_ready) absorb_item(i_data_byte, i_byte_present, i_end_of_message);
            if (o_valid && i_ready) begin
                if (digest_q.size() == 0) begin
                    $error("digest word transaction with nothing expected: word %h index %0d",
                           o_digest_word, o_word_index);
                    fails++;
                end else begin
                    exp_w = digest_q.pop_front();
                    checked++;
                    if (o_digest_word !== exp_w.word) begin
                        $error("digest_word expected %h actual %h", exp_w.word, o_digest_word);
                        fails++;
                    end
                    if (o_word_index !== exp_w.idx) begin
                        $error("word_index expected %0d actual %0d", exp_w.idx, o_word_index);
                        fails++;
                    end
                    if (o_last_word !== exp_w.last) begin
                        $error("last_word expected %0d actual %0d", exp_w.last, o_last_word);
                        fails++;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_byte_present;
    logic        i_end_of_message;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    int fail_count;
    int words_pending;
    int words_checked;
    int items;
    int byte_items;
    int messages;
    int stall_cycles;
    bit allow_idle;
    bit long_hold_done;

    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 1000;

    sha256_stream_hasher DUT (.*);

    sha256_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data_byte, .i_byte_present,
        .i_end_of_message, .o_valid, .i_ready, .o_digest_word, .o_word_index,
        .o_last_word,
        .o_fail_count    (fail_count),
        .o_words_pending (words_pending),
        .o_words_checked (words_checked)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_item(input logic [7:0] data, input logic present, input logic eom);
        if (allow_idle && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_data_byte      <= data;
        i_byte_present   <= present;
        i_end_of_message <= eom;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        items++;
        if (present) byte_items++;
        if (eom) messages++;
    endtask

    task automatic send_message(input int len, input bit empty_close);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, !empty_close && i == len - 1);
        end
        if (empty_close || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // The receiver holds off once for a long stretch so the block stalls its input until the digest is taken.
    always begin
        @(negedge i_clk);
        if (messages == 6 && !long_hold_done) begin
            long_hold_done = 1'b1;
            i_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge i_clk);
            i_ready <= 1'b1;
        end else if (allow_idle && $urandom_range(0, 4) == 0) begin
            i_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
            i_ready <= 1'b1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // A run is stuck if no transaction happens on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int len;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_data_byte      = 8'h00;
        i_byte_present   = 1'b0;
        i_end_of_message = 1'b0;
        items            = 0;
        byte_items       = 0;
        messages         = 0;
        allow_idle       = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty message, single extreme bytes, idle items, "abc" and a late empty close.
        send_item(8'hA5, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h78, 1'b1, 1'b0);
        send_item(8'hC3, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b0);

        allow_idle = 1'b1;
        while (items < 320) begin
            case ($urandom_range(0, 9))
                6:       len = $urandom_range(55, 56);
                7:       len = $urandom_range(63, 65);
                8:       len = $urandom_range(119, 121);
                9:       len = $urandom_range(0, 130);
                default: len = $urandom_range(0, 12);
            endcase
            if (items > 270) allow_idle = 1'b0;
            send_message(len, $urandom_range(0, 3) == 0);
        end
        i_valid <= 1'b0;

        while (words_pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Hashed %0d messages from %0d items holding %0d bytes; %0d digest words compared.",
                 messages, items, byte_items, words_checked);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
